// File: rtl/fccsr_pkg.sv
`default_nettype none

package fccsr_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int SECTOR_BYTES      = 512;
    localparam int MAX_SECTORS       = 64;

    localparam logic [15:0] MAX_BYTES    = 16'(MAX_SECTORS * SECTOR_BYTES);
    localparam logic [9:0]  SECTOR_CNT   = 10'(SECTOR_BYTES);
    localparam logic [14:0] SECTOR_STEP  = 15'(SECTOR_BYTES);

    // FAT32 chain markers
    localparam logic [27:0] CHAIN_END_MIN = 28'hFFFFFF8;
    localparam logic [27:0] CHAIN_BAD     = 28'hFFFFFF7;

    // opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CHAIN_END = 2'd1;
    localparam logic [1:0] ST_BAD       = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    // configuration register indexes
    localparam logic CFG_DATA_START = 1'b0;
    localparam logic CFG_SPC        = 1'b1;

    localparam logic [7:0] SPC_RESET = 8'd8;

    typedef struct packed {
        logic        opcode;
        logic [11:0] table_index;
        logic [27:0] table_value;
        logic [27:0] start_cluster;
        logic [15:0] bytes_requested;
        logic [31:0] file_size;
        logic [31:0] stream_position;
    } t_item;

    typedef struct packed {
        logic [31:0] sector_lba;
        logic [9:0]  byte_count;
        logic [14:0] buffer_offset;
        logic [1:0]  status;
        logic        last;
    } t_result;

    // classified command between front and back
    typedef struct packed {
        logic        op;
        logic [11:0] table_index;
        logic [27:0] cluster;     // table value for a load, start cluster for a read
        logic [15:0] byte_total;  // clamped byte count for a read
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/fccsr_ram.sv
`default_nettype none

module fccsr_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/fccsr_fifo.sv
`default_nettype none

module fccsr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [AW:0]      r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = w_push ? AW'(r_wptr + AW'(1)) : r_wptr;
        n_rptr  = w_pop ? AW'(r_rptr + AW'(1)) : r_rptr;
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + (AW+1)'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fccsr_front.sv
`default_nettype none

module fccsr_front
    import fccsr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_cmd_pop,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);

    logic [31:0] w_left;
    logic [15:0] w_bytes;
    t_cmd        w_cmd;
    logic        w_empty;

    // clamp to what is left in the file and to the per-request ceiling
    always_comb begin
        w_left  = (i_item.stream_position <= i_item.file_size)
                ? (i_item.file_size - i_item.stream_position) : 32'd0;
        w_bytes = i_item.bytes_requested;
        if ({16'd0, w_bytes} > w_left) begin
            w_bytes = w_left[15:0];
        end
        if (w_bytes > MAX_BYTES) begin
            w_bytes = MAX_BYTES;
        end
        w_cmd.op          = i_item.opcode;
        w_cmd.table_index = i_item.table_index;
        w_cmd.cluster     = (i_item.opcode == OP_LOAD) ? i_item.table_value
                                                       : i_item.start_cluster;
        w_cmd.byte_total  = w_bytes;
    end

    fccsr_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (w_empty)
    );

    assign o_cmd_valid = !w_empty;

endmodule

`default_nettype wire

// File: rtl/fccsr_back.sv
`default_nettype none

module fccsr_back
    import fccsr_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_data_start,
    input  wire logic [7:0]  i_spc,
    input  wire logic        i_cmd_valid,
    input  wire t_cmd        i_cmd,
    output logic             o_cmd_pop,
    input  wire logic        i_res_full,
    output logic             o_res_push,
    output t_result          o_res
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_ZERO  = 8'b00000010,
        S_MUL   = 8'b00000100,
        S_BASE  = 8'b00001000,
        S_EMIT  = 8'b00010000,
        S_LOOK  = 8'b00100000,
        S_CHECK = 8'b01000000,
        S_DRAIN = 8'b10000000
    } t_state;

    t_state      r_state, n_state;
    logic [27:0] r_cluster, n_cluster;
    logic [15:0] r_bytes, n_bytes;
    logic [8:0]  r_sec, n_sec;
    logic [14:0] r_off, n_off;
    logic [31:0] r_lba, n_lba;
    logic [31:0] r_prod, n_prod;
    logic [1:0]  r_st, n_st;

    logic [8:0]  w_spc;
    logic [9:0]  w_cnt;
    logic [15:0] w_rem;
    logic        w_wrap;
    logic        w_in_table;
    logic [31:0] w_tidx32, w_clu32;
    logic        w_we;
    logic [27:0] w_rdata;

    assign w_spc      = (i_spc == 8'd0) ? 9'd256 : {1'b0, i_spc};
    assign w_cnt      = (r_bytes > {6'd0, SECTOR_CNT}) ? SECTOR_CNT : r_bytes[9:0];
    assign w_rem      = r_bytes - {6'd0, w_cnt};
    assign w_wrap     = (9'(r_sec + 9'd1) == w_spc);
    assign w_clu32    = {4'd0, r_cluster};
    assign w_tidx32   = 32'(i_cmd.table_index);
    assign w_in_table = (w_clu32 < 32'(TABLE_ENTRIES));

    assign w_we = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.op == OP_LOAD)
               && (w_tidx32 < 32'(TABLE_ENTRIES));

    fccsr_ram #(
        .WIDTH (28),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_tidx32[AW-1:0]),
        .i_wdata (i_cmd.cluster),
        .i_raddr (w_clu32[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_cluster  = r_cluster;
        n_bytes    = r_bytes;
        n_sec      = r_sec;
        n_off      = r_off;
        n_lba      = r_lba;
        n_prod     = r_prod;
        n_st       = r_st;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '{sector_lba: r_lba, byte_count: w_cnt, buffer_offset: r_off,
                       status: ST_OK, last: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == OP_READ) begin
                        n_cluster = i_cmd.cluster;
                        n_bytes   = i_cmd.byte_total;
                        n_sec     = '0;
                        n_off     = '0;
                        n_st      = ST_OK;
                        n_state   = (i_cmd.byte_total == 16'd0) ? S_ZERO : S_MUL;
                    end
                end
            end
            S_ZERO: begin
                o_res = '{sector_lba: 32'd0, byte_count: 10'd0, buffer_offset: 15'd0,
                          status: ST_OK, last: 1'b1};
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_MUL: begin
                n_prod  = (w_clu32 - 32'd2) * {23'd0, w_spc};
                n_state = S_BASE;
            end
            S_BASE: begin
                n_lba   = i_data_start + r_prod;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_rem == 16'd0) begin
                    o_res.last = 1'b1;
                    if (!i_res_full) begin
                        o_res_push = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (w_wrap) begin
                    // cluster used up: hold this sector until the chain says what follows
                    n_state = S_LOOK;
                end else if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_lba      = r_lba + 32'd1;
                    n_off      = r_off + SECTOR_STEP;
                    n_bytes    = w_rem;
                    n_sec      = r_sec + 9'd1;
                end
            end
            S_LOOK: begin
                if (w_in_table) begin
                    n_state = S_CHECK;
                end else begin
                    n_st    = ST_RANGE;
                    n_state = S_DRAIN;
                end
            end
            S_CHECK: begin
                if (w_rdata >= CHAIN_END_MIN) begin
                    n_st = ST_CHAIN_END;
                end else if (w_rdata == CHAIN_BAD) begin
                    n_st = ST_BAD;
                end else begin
                    n_cluster = w_rdata;
                end
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                o_res.status = r_st;
                o_res.last   = (r_st != ST_OK);
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_st != ST_OK) begin
                        n_state = S_IDLE;
                    end else begin
                        n_bytes = w_rem;
                        n_off   = r_off + SECTOR_STEP;
                        n_sec   = '0;
                        n_state = S_MUL;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cluster <= n_cluster;
        r_bytes   <= n_bytes;
        r_sec     <= n_sec;
        r_off     <= n_off;
        r_lba     <= n_lba;
        r_prod    <= n_prod;
        r_st      <= n_st;
    end

endmodule

`default_nettype wire

// File: rtl/fat_cluster_chain_sector_reader_core.sv
`default_nettype none

// FAT32 cluster-chain sector reader. Items enter through a queue-style port
// (push/full): opcode 0 loads one allocation-table entry, opcode 1 is a read
// request that is clamped to the bytes left in the file and to 64 sectors,
// then turned into one result per 512-byte sector (LBA, byte count, buffer
// offset), walking the cluster chain from the start cluster. Results leave
// through a queue-style port (empty/pop); the final one carries last, and a
// nonzero status when the chain ends early, hits a bad cluster, or points
// outside the table. A request for zero bytes yields one empty result with
// last set. Flow: a load writes the table entry from idle; a read leaves the
// command queue, sets up each cluster (LBA multiply, then base add), emits
// one sector per cycle while the result queue has room, and at every
// cluster boundary holds the last sector, reads the table through the
// registered read port of the table memory, then checks the entry (no read
// or check when the cluster lies outside the table). The table memory is
// not cleared: reading an entry that was never loaded gives unspecified
// values. Registers (write only, take effect at once; the user changes them
// only while idle, the block itself does not enforce it): index 0 data
// start sector, index 1 sectors per cluster (0 means 256).

module fat_cluster_chain_sector_reader_core
    import fccsr_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request side
    input  wire logic        i_push,
    input  wire t_item       i_item,
    output logic             o_full,
    // result side
    input  wire logic        i_pop,
    output t_result          o_result,
    output logic             o_empty,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic [31:0] r_data_start;
    logic [7:0]  r_spc;

    logic        w_cmd_valid, w_cmd_pop;
    t_cmd        w_cmd;
    logic        w_res_full, w_res_push;
    t_result     w_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_start <= 32'd0;
            r_spc        <= SPC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DATA_START: r_data_start <= i_cfg_data;
                CFG_SPC:        r_spc        <= i_cfg_data[7:0];
                default:        r_spc        <= r_spc;
            endcase
        end
    end

    // front: clamps and classifies, short command queue to the back
    fccsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    // back: table writes, chain walk, per-sector results
    fccsr_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_data_start (r_data_start),
        .i_spc        (r_spc),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .i_res_full   (w_res_full),
        .o_res_push   (w_res_push),
        .o_res        (w_res)
    );

    // result queue decouples the walk from the consumer
    fccsr_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty)
    );

endmodule

`default_nettype wire

// File: rtl/fccsr_checker.sv
`default_nettype none

module fccsr_checker
    import fccsr_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_pop,
    input wire t_result     o_result,
    input wire logic        o_empty
);

    // nothing waits right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    // a waiting result holds until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_result)))
        else $error("waiting result changed");

    // only the empty answer to a zero-byte request has no bytes
    a_no_empty_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.byte_count == 10'd0) |->
        (o_result.last && o_result.status == ST_OK && o_result.sector_lba == 32'd0))
        else $error("zero-byte sector result");

    // an early stop is flagged only on the final result
    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.status != ST_OK) |-> o_result.last)
        else $error("status on a non-final result");

    // a sector never delivers more than its size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_result.byte_count <= SECTOR_CNT))
        else $error("byte count above sector size");

endmodule

bind fat_cluster_chain_sector_reader_core fccsr_checker u_fccsr_checker (.*);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import fccsr_pkg::*;

    localparam int TABLE_SIZE    = TABLE_ENTRIES_DEF;
    localparam int SETTLE_CYCLES = 40;   // well past the load latency of the core
    localparam int TOTAL_ITEMS   = 180;  // items sent over the whole run
    localparam int PHASE_ITEMS   = 30;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_push;
    t_item       i_item;
    logic        o_full;
    logic        i_pop;
    t_result     o_result;
    logic        o_empty;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    fat_cluster_chain_sector_reader_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .i_pop       (i_pop),
        .o_result    (o_result),
        .o_empty     (o_empty),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow state: our own copy of the allocation table and registers.
    // fat_loaded tracks which entries hold a defined value; the stimulus
    // never lets a chain walk look up an entry that was never loaded.
    // ------------------------------------------------------------------
    logic [27:0] fat_copy [TABLE_SIZE];
    bit          fat_loaded [TABLE_SIZE];
    logic [31:0] cfg_data_start;
    logic [7:0]  cfg_spc;

    t_result     sector_q [$];   // sector reads still owed by the core, oldest first
    int          n_err = 0;
    int          n_sent = 0;     // items transferred so far
    bit          calm = 1'b0;    // no idling on either side while set

    // ------------------------------------------------------------------
    // Chain walker. With emit set it queues the expected sector reads of
    // one request. With emit clear it only walks, and returns the first
    // table entry the walk would look up that was never loaded (-1 if none).
    // ------------------------------------------------------------------
    function automatic int walk_chain(t_item it, bit emit);
        logic [31:0] left, nbytes, spc, clus, nxt, sec, off;
        logic [9:0]  cnt;
        logic [1:0]  st;
        t_result     r;
        left   = (it.stream_position <= it.file_size) ?
                 it.file_size - it.stream_position : 32'd0;
        nbytes = {16'd0, it.bytes_requested};
        if (nbytes > left)
            nbytes = left;
        if (nbytes > MAX_BYTES)
            nbytes = {16'd0, MAX_BYTES};

        // nothing to deliver: one empty final sector
        if (nbytes == 0) begin
            r = '0;
            r.last = 1'b1;
            if (emit)
                sector_q.push_back(r);
            return -1;
        end

        spc  = (cfg_spc == 8'd0) ? 32'd256 : {24'd0, cfg_spc};
        clus = {4'd0, it.start_cluster};
        sec  = 0;
        off  = 0;
        for (int k = 0; k < MAX_SECTORS && nbytes != 0; k++) begin
            cnt = (nbytes > SECTOR_BYTES) ? SECTOR_CNT : nbytes[9:0];
            nbytes = nbytes - cnt;
            r.sector_lba    = cfg_data_start + (clus - 32'd2) * spc + sec;
            r.byte_count    = cnt;
            r.buffer_offset = off[14:0];
            r.status        = ST_OK;
            r.last          = (nbytes == 0);
            off = off + cnt;
            sec = sec + 1;
            // cluster used up with bytes still owed: follow the chain
            if (nbytes != 0 && sec >= spc) begin
                st = ST_OK;
                if (clus >= TABLE_SIZE) begin
                    st = ST_RANGE;
                end else if (!fat_loaded[clus]) begin
                    return int'(clus);
                end else begin
                    nxt = {4'd0, fat_copy[clus]};
                    if (nxt >= CHAIN_END_MIN)
                        st = ST_CHAIN_END;
                    else if (nxt == CHAIN_BAD)
                        st = ST_BAD;
                    else
                        clus = nxt;
                end
                if (st != ST_OK) begin
                    // the sector just produced closes the request
                    r.status = st;
                    r.last   = 1'b1;
                    if (emit)
                        sector_q.push_back(r);
                    return -1;
                end
                sec = 0;
            end
            if (emit)
                sector_q.push_back(r);
        end
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random pop stalls, every popped result checked in order
    // ------------------------------------------------------------------
    task automatic flag_field(string what, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s expected %h actual %h", $time, what, want, got);
        n_err++;
    endtask

    task automatic check_sector(t_result got);
        t_result want;
        if (sector_q.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, got);
            n_err++;
            return;
        end
        want = sector_q.pop_front();
        if (got.sector_lba !== want.sector_lba)
            flag_field("sector_lba", want.sector_lba, got.sector_lba);
        if (got.byte_count !== want.byte_count)
            flag_field("byte_count", want.byte_count, got.byte_count);
        if (got.buffer_offset !== want.buffer_offset)
            flag_field("buffer_offset", want.buffer_offset, got.buffer_offset);
        if (got.status !== want.status)
            flag_field("status", want.status, got.status);
        if (got.last !== want.last)
            flag_field("last", want.last, got.last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            // a transfer happened at this edge if pop was high and a result was there
            if (i_pop && !o_empty)
                check_sector(o_result);
            i_pop <= calm || ($urandom_range(99) >= 6);
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Sends one item and leaves push high on return; the shadow state is
    // updated at the edge of the transfer, so it tracks the core's order.
    task automatic push_item(t_item it);
        while (!calm && $urandom_range(99) < 6) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_full)
            @(posedge i_clk);
        n_sent++;
        if (it.opcode == OP_LOAD) begin
            fat_copy[it.table_index]   = it.table_value;
            fat_loaded[it.table_index] = 1'b1;
        end else begin
            void'(walk_chain(it, 1'b1));
        end
    endtask

    function automatic t_item rand_item();
        t_item it;
        it.opcode          = 1'($urandom);
        it.table_index     = 12'($urandom);
        it.table_value     = 28'($urandom);
        it.start_cluster   = 28'($urandom);
        it.bytes_requested = 16'($urandom);
        it.file_size       = $urandom;
        it.stream_position = $urandom;
        return it;
    endfunction

    task automatic load_entry(logic [11:0] idx, logic [27:0] val);
        t_item it;
        it             = rand_item();
        it.opcode      = OP_LOAD;
        it.table_index = idx;
        it.table_value = val;
        push_item(it);
    endtask

    // Next-cluster value for an entry that a walk is about to reach.
    // Mostly keeps the chain going so long reads cross many clusters.
    function automatic logic [27:0] pick_link();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 70)
            return 28'($urandom_range(2, TABLE_SIZE - 1));
        if (p < 80)
            return CHAIN_END_MIN + 28'($urandom_range(0, 7));
        if (p < 86)
            return CHAIN_BAD;
        if (p < 92)
            return 28'($urandom_range(TABLE_SIZE, 32'h0FFF_FFF6));
        return 28'($urandom_range(0, 1));
    endfunction

    // Fill in every entry the walk would touch before it was loaded,
    // then send the read itself.
    task automatic request_read(t_item it);
        int idx;
        idx = walk_chain(it, 1'b0);
        while (idx >= 0) begin
            load_entry(12'(idx), pick_link());
            idx = walk_chain(it, 1'b0);
        end
        push_item(it);
    endtask

    task automatic read_from(logic [27:0] clus, logic [15:0] nbytes,
                             logic [31:0] fsize, logic [31:0] pos);
        t_item it;
        it                 = rand_item();
        it.opcode          = OP_READ;
        it.start_cluster   = clus;
        it.bytes_requested = nbytes;
        it.file_size       = fsize;
        it.stream_position = pos;
        request_read(it);
    endtask

    // Everything owed has come back and the core has had time to finish
    // any load still in flight.
    task automatic wait_idle();
        i_push <= 1'b0;
        while (sector_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(logic idx, logic [31:0] val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DATA_START)
            cfg_data_start = val;
        else
            cfg_spc = val[7:0];
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Hand-built chains covering each way a walk can end, plus the
    // clamping corners of the byte count.
    task automatic test_chain_cases();
        set_reg(CFG_DATA_START, 32'd100);
        set_reg(CFG_SPC, 32'd2);
        load_entry(12'd2, 28'd3);
        load_entry(12'd3, 28'hFFF_FFFF);       // top end marker
        load_entry(12'd5, CHAIN_BAD);
        load_entry(12'd6, 28'd4096);           // first cluster past the table
        load_entry(12'd10, 28'd0);
        load_entry(12'd0, 28'd1);              // clusters 0 and 1 are followed as is
        load_entry(12'd1, CHAIN_END_MIN);      // lowest end marker
        load_entry(12'd20, 28'd20);            // self loop
        load_entry(12'hFFF, CHAIN_END_MIN);
        read_from(28'd2, 16'd2048, 32'd2048, 32'd0);           // two whole clusters
        read_from(28'd2, 16'd4096, 32'hFFFF_FFFF, 32'd0);      // chain ends early
        read_from(28'd5, 16'd2000, 32'd5000, 32'd0);           // bad cluster
        read_from(28'd6, 16'd3000, 32'd10000, 32'd0);          // walks off the table
        read_from(28'd10, 16'd4000, 32'd4000, 32'd0);          // through 0 and 1
        read_from(28'd20, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);     // saturates at 64 sectors
        read_from(28'd2, 16'd0, 32'd1000, 32'd0);              // zero request
        read_from(28'd2, 16'd1000, 32'd500, 32'd501);          // position past end
        read_from(28'd2, 16'd1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // position at end
        read_from(28'd2, 16'd30000, 32'd1000, 32'd100);        // clamped to what is left
        read_from(28'd2, 16'd513, 32'd513, 32'd0);             // partial last sector
        read_from(28'hFFF_FFFF, 16'd512, 32'd512, 32'd0);      // highest cluster number
        read_from(28'd0, 16'd1024, 32'd1024, 32'd0);           // cluster below 2
        read_from(28'd4095, 16'd1536, 32'd1536, 32'd0);        // last table entry
    endtask

    // Register extremes: base at the top of the LBA space, one sector per
    // cluster, 0 meaning 256, and the largest sizes.
    task automatic test_register_extremes();
        set_reg(CFG_DATA_START, 32'hFFFF_FFFF);
        set_reg(CFG_SPC, 32'd1);
        read_from(28'd2, 16'd3000, 32'd3000, 32'd0);
        read_from(28'hFFF_FFFF, 16'd512, 32'd512, 32'd0);
        set_reg(CFG_SPC, {24'hA5A5A5, 8'd0});   // upper bits are don't-care
        read_from(28'd300, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        set_reg(CFG_SPC, 32'd128);
        read_from(28'd2, 16'd32768, 32'hFFFF_FFFF, 32'd0);
        set_reg(CFG_SPC, 32'd255);
        read_from(28'd4000, 16'd20000, 32'd20000, 32'd0);
        set_reg(CFG_DATA_START, 32'd0);
        read_from(28'd2, 16'd1500, 32'd1500, 32'd0);
    endtask

    function automatic logic [7:0] pick_spc();
        case ($urandom_range(11))
            0: return 8'd1;
            1: return 8'd2;
            2: return 8'd3;
            3: return 8'd4;
            4: return 8'd8;
            5: return 8'd16;
            6: return 8'd32;
            7: return 8'd64;
            8: return 8'd128;
            9: return 8'd0;
            10: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_base();
        case ($urandom_range(3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'hFFFF_F000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item rand_read();
        t_item       it;
        int unsigned p;
        it        = rand_item();
        it.opcode = OP_READ;

        // most requests are short, a few hit the 64-sector ceiling
        p = $urandom_range(99);
        if (p < 50)
            it.bytes_requested = 16'($urandom_range(1, 2048));
        else if (p < 62)
            it.bytes_requested = 16'(512 * $urandom_range(1, 64));
        else if (p < 72)
            it.bytes_requested = 16'($urandom_range(2049, 32768));
        else if (p < 82)
            it.bytes_requested = 16'($urandom_range(32769, 65535));
        else if (p < 90)
            it.bytes_requested = 16'd0;

        p = $urandom_range(99);
        if (p < 70) begin
            it.stream_position = it.file_size - $urandom_range(0, 70000);
        end else if (p < 85) begin
            it.file_size       = $urandom_range(0, 70000);
            it.stream_position = 32'd0;
        end

        p = $urandom_range(99);
        if (p < 80)
            it.start_cluster = 28'($urandom_range(2, TABLE_SIZE - 1));
        else if (p < 88)
            it.start_cluster = 28'($urandom_range(0, 1));
        return it;
    endfunction

    // Phases of random traffic, each under its own register setting, until
    // the item budget of the run is spent. The first phase runs with no
    // idling at all.
    task automatic test_random_reads();
        int phase;
        phase = 0;
        while (n_sent < TOTAL_ITEMS) begin
            set_reg(CFG_DATA_START, pick_base());
            set_reg(CFG_SPC, {24'($urandom), pick_spc()});
            calm = (phase == 0);
            for (int i = 0; i < PHASE_ITEMS && n_sent < TOTAL_ITEMS; i++) begin
                if ($urandom_range(3) == 0)
                    load_entry(12'($urandom),
                               $urandom_range(1) ? 28'($urandom) : pick_link());
                else
                    request_read(rand_read());
            end
            phase = phase + 1;
        end
        wait_idle();
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_push      <= 1'b0;
        i_item      <= '0;
        i_pop       <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_DATA_START;
        i_cfg_data  <= '0;
        cfg_data_start = 32'd0;
        cfg_spc        = SPC_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_chain_cases();
        test_register_extremes();
        test_random_reads();

        wait_idle();
        if (n_err == 0 && sector_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // hang guard
    initial begin
        #5ms;
        $display("tb: errors");
        $finish;
    end

endmodule

// File: fat_cluster_chain_sector_reader_core.f
rtl/fccsr_pkg.sv
rtl/fccsr_ram.sv
rtl/fccsr_fifo.sv
rtl/fccsr_front.sv
rtl/fccsr_back.sv
rtl/fat_cluster_chain_sector_reader_core.sv
rtl/fccsr_checker.sv
tb/tb.sv
